>>> rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MCO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MCO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MCO_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCO_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mco_pkg.sv
`default_nettype none

package mco_pkg;

  localparam int COORD_W   = 14;
  localparam int OFFSET_W  = 28;
  localparam int PITCH_W   = 15;
  localparam int COLOR_W   = 32;
  localparam int CENTER_W  = 12;
  localparam int IDX_W     = 3;
  localparam int BPP_SHIFT = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 15'd4096;
  localparam logic [IDX_W-1:0]   IDX_LAST    = 3'd7;

  // how one of the eight symmetric pixels is formed from the octant point
  typedef struct packed {
    logic x_use_y;
    logic x_neg;
    logic y_use_y;
    logic y_neg;
  } term_t;

  typedef struct packed {
    logic load;
    logic done;
  } launch_t;

  // neg: center - v, otherwise center + v - 1
  function automatic term_t pixel_term(input logic [IDX_W-1:0] k);
    term_t t;
    t = '0;
    unique case (k)
      3'd0: t = '{x_use_y: 1'b0, x_neg: 1'b0, y_use_y: 1'b1, y_neg: 1'b0};
      3'd1: t = '{x_use_y: 1'b1, x_neg: 1'b0, y_use_y: 1'b0, y_neg: 1'b0};
      3'd2: t = '{x_use_y: 1'b0, x_neg: 1'b1, y_use_y: 1'b1, y_neg: 1'b0};
      3'd3: t = '{x_use_y: 1'b1, x_neg: 1'b0, y_use_y: 1'b0, y_neg: 1'b1};
      3'd4: t = '{x_use_y: 1'b0, x_neg: 1'b0, y_use_y: 1'b1, y_neg: 1'b1};
      3'd5: t = '{x_use_y: 1'b1, x_neg: 1'b1, y_use_y: 1'b0, y_neg: 1'b0};
      3'd6: t = '{x_use_y: 1'b0, x_neg: 1'b1, y_use_y: 1'b1, y_neg: 1'b1};
      3'd7: t = '{x_use_y: 1'b1, x_neg: 1'b1, y_use_y: 1'b0, y_neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mco_octant_walk.sv
`default_nettype none

module mco_octant_walk #(
  parameter int RADIUS_BITS = 11
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_operation,
  input  wire  [mco_pkg::CENTER_W-1:0]        in_center_x,
  input  wire  [mco_pkg::CENTER_W-1:0]        in_center_y,
  input  wire  [RADIUS_BITS-1:0]              in_radius,
  input  wire  [mco_pkg::COLOR_W-1:0]         in_color,
  input  wire                                 can_load,
  output mco_pkg::launch_t                    launch,
  output logic [RADIUS_BITS-1:0]              oct_x,
  output logic [RADIUS_BITS:0]                oct_y,
  output logic [mco_pkg::CENTER_W-1:0]        center_col,
  output logic [mco_pkg::CENTER_W-1:0]        center_row,
  output logic [mco_pkg::COLOR_W-1:0]         draw_color
);

  localparam int XW = RADIUS_BITS;
  localparam int YW = RADIUS_BITS + 1;
  localparam int EW = RADIUS_BITS + 3;

  logic                         active_r, active_nxt;
  logic [XW-1:0]                x_r, x_nxt;
  logic [YW-1:0]                y_r, y_nxt;
  logic [EW-1:0]                err_r, err_nxt;
  logic [mco_pkg::CENTER_W-1:0] cx_r, cx_nxt;
  logic [mco_pkg::CENTER_W-1:0] cy_r, cy_nxt;
  logic [mco_pkg::COLOR_W-1:0]  color_r, color_nxt;

  logic          accept;
  logic          has_pixels;
  logic [EW-1:0] e_add;
  logic [EW-1:0] e_dec;
  logic [XW-1:0] x_dec;
  logic [XW-1:0] step_x;
  logic [YW-1:0] step_y;
  logic [EW-1:0] step_e;
  logic          step_done;

  assign in_ready   = can_load;
  assign accept     = in_valid && in_ready;
  assign has_pixels = active_r && ({1'b0, x_r} >= y_r);

  // decision update for one step
  assign e_add     = err_r + {1'b0, y_r, 1'b0};
  assign x_dec     = x_r - XW'(1);
  assign e_dec     = e_add - {2'b00, x_dec, 1'b0} + EW'(1);
  assign step_x    = e_add[EW-1] ? x_r : x_dec;
  assign step_e    = e_add[EW-1] ? e_add : e_dec;
  assign step_y    = y_r + YW'(1);
  assign step_done = {1'b0, step_x} < step_y;

  always_comb begin
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    if (accept) begin
      if (in_operation == mco_pkg::OP_START) begin
        active_nxt = 1'b1;
        x_nxt      = in_radius;
        y_nxt      = YW'(1);
        err_nxt    = EW'(0) - {3'b000, in_radius};
        cx_nxt     = in_center_x;
        cy_nxt     = in_center_y;
        color_nxt  = in_color;
      end else if (has_pixels) begin
        active_nxt = !step_done;
        x_nxt      = step_x;
        y_nxt      = step_y;
        err_nxt    = step_e;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      err_r    <= err_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
    end
  end

  // the emitter snapshots the pre-update point on load
  assign launch.load = accept && (in_operation == mco_pkg::OP_STEP) && has_pixels;
  assign launch.done = step_done;
  assign oct_x       = x_r;
  assign oct_y       = y_r;
  assign center_col  = cx_r;
  assign center_row  = cy_r;
  assign draw_color  = color_r;

endmodule

`default_nettype wire

>>> rtl/mco_pixel_emit.sv
`default_nettype none

module mco_pixel_emit #(
  parameter int RADIUS_BITS = 11
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  mco_pkg::launch_t                    launch,
  input  wire  [RADIUS_BITS-1:0]              oct_x,
  input  wire  [RADIUS_BITS:0]                oct_y,
  input  wire  [mco_pkg::CENTER_W-1:0]        center_col,
  input  wire  [mco_pkg::CENTER_W-1:0]        center_row,
  input  wire  [mco_pkg::COLOR_W-1:0]         draw_color,
  input  wire                                 cfg_valid,
  input  wire  [mco_pkg::PITCH_W-1:0]         cfg_row_pitch,
  output logic                                can_load,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [mco_pkg::COORD_W-1:0]  out_pixel_x,
  output logic signed [mco_pkg::COORD_W-1:0]  out_pixel_y,
  output logic signed [mco_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic [mco_pkg::COLOR_W-1:0]         out_pixel_value,
  output logic                                out_last_of_step,
  output logic                                out_circle_done
);

  localparam int VW = RADIUS_BITS + 1;
  // wide enough for center plus or minus the octant point, sign included
  localparam int CW = ((VW > mco_pkg::CENTER_W) ? VW : mco_pkg::CENTER_W) + 2;
  localparam int PW = CW + mco_pkg::PITCH_W + 1;

  logic                         job_valid_r, job_valid_nxt;
  logic [mco_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [RADIUS_BITS-1:0]       jx_r;
  logic [VW-1:0]                jy_r;
  logic [mco_pkg::CENTER_W-1:0] jcx_r;
  logic [mco_pkg::CENTER_W-1:0] jcy_r;
  logic [mco_pkg::COLOR_W-1:0]  jcol_r;
  logic                         jdone_r;
  logic [mco_pkg::PITCH_W-1:0]  pitch_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [mco_pkg::COORD_W-1:0]   px_r;
  logic [mco_pkg::COORD_W-1:0]   py_r;
  logic [mco_pkg::OFFSET_W-1:0]  off_r;
  logic [mco_pkg::COLOR_W-1:0]   col_r;
  logic                          last_r;
  logic                          done_r;

  logic                          advance;
  logic                          is_last;
  mco_pkg::term_t                term;
  logic [VW-1:0]                 xv;
  logic [VW-1:0]                 yv;
  logic [CW-1:0]                 cxe;
  logic [CW-1:0]                 cye;
  logic [CW-1:0]                 px;
  logic [CW-1:0]                 py;
  logic signed [PW-1:0]          prod;
  logic [mco_pkg::OFFSET_W-1:0]  px_off;
  logic [mco_pkg::OFFSET_W-1:0]  off;

  assign advance  = job_valid_r && (!out_valid_r || out_ready);
  assign is_last  = (idx_r == mco_pkg::IDX_LAST);
  assign can_load = !job_valid_r || (advance && is_last);

  // pixel of the current index
  assign term = mco_pkg::pixel_term(idx_r);
  assign xv   = term.x_use_y ? jy_r : {1'b0, jx_r};
  assign yv   = term.y_use_y ? jy_r : {1'b0, jx_r};
  assign cxe  = CW'(jcx_r);
  assign cye  = CW'(jcy_r);
  assign px   = term.x_neg ? (cxe - CW'(xv)) : (cxe + CW'(xv) - CW'(1));
  assign py   = term.y_neg ? (cye - CW'(yv)) : (cye + CW'(yv) - CW'(1));

  assign prod   = $signed(py) * $signed({1'b0, pitch_r});
  assign px_off = mco_pkg::OFFSET_W'($signed(px)) << mco_pkg::BPP_SHIFT;
  assign off    = prod[mco_pkg::OFFSET_W-1:0] + px_off;

  always_comb begin
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    if (launch.load) begin
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (advance) begin
      idx_nxt = idx_r + mco_pkg::IDX_W'(1);
      if (is_last) begin
        job_valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      pitch_r     <= mco_pkg::PITCH_RESET;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        pitch_r <= cfg_row_pitch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch.load) begin
      jx_r    <= oct_x;
      jy_r    <= oct_y;
      jcx_r   <= center_col;
      jcy_r   <= center_row;
      jcol_r  <= draw_color;
      jdone_r <= launch.done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px_r   <= px[mco_pkg::COORD_W-1:0];
      py_r   <= py[mco_pkg::COORD_W-1:0];
      off_r  <= off;
      col_r  <= jcol_r;
      last_r <= is_last;
      done_r <= is_last && jdone_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = $signed(px_r);
  assign out_pixel_y      = $signed(py_r);
  assign out_byte_offset  = $signed(off_r);
  assign out_pixel_value  = col_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

endmodule

`default_nettype wire

>>> rtl/midpoint_circle_outline_unit.sv
// midpoint circle outline unit
// input channel (in_*): a request with in_operation = start latches center,
//   radius and color and sets up the octant walk; it produces no pixels.
//   a request with in_operation = step produces the eight symmetric pixels
//   of the current octant point, or nothing when no circle is open or x < y.
// output channel (out_*): one pixel per transfer with its column, row,
//   byte offset (row * row_pitch + 4 * column, 28-bit wrap) and color;
//   out_last_of_step marks the eighth pixel, out_circle_done marks the
//   eighth pixel of the step that closes the circle.
// config channel (cfg_*): always ready, writes row_pitch; write only while idle.
// a taken step request lands in the emitter's job registers, then its first
//   pixel goes to the output register unless the receiver holds an earlier one.
// throughput: one pixel per cycle while the receiver keeps taking pixels; the
//   emitter's pixel counter walks the eight pixels. the next step request is
//   taken in the cycle the eighth pixel moves to the output register.
// a stalled receiver holds the output register and the emitter; requests
//   back up through in_ready. synchronous reset closes any circle, drops
//   pending pixels and sets row_pitch to 4096.
`default_nettype none
`include "assert_macros.svh"

module midpoint_circle_outline_unit #(
  parameter int RADIUS_BITS = 11
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_operation,
  input  wire  [mco_pkg::CENTER_W-1:0]        in_center_x,
  input  wire  [mco_pkg::CENTER_W-1:0]        in_center_y,
  input  wire  [RADIUS_BITS-1:0]              in_radius,
  input  wire  [mco_pkg::COLOR_W-1:0]         in_color,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [mco_pkg::COORD_W-1:0]  out_pixel_x,
  output logic signed [mco_pkg::COORD_W-1:0]  out_pixel_y,
  output logic signed [mco_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic [mco_pkg::COLOR_W-1:0]         out_pixel_value,
  output logic                                out_last_of_step,
  output logic                                out_circle_done,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [mco_pkg::PITCH_W-1:0]         cfg_row_pitch
);

  mco_pkg::launch_t             launch;
  logic                         can_load;
  logic [RADIUS_BITS-1:0]       oct_x;
  logic [RADIUS_BITS:0]         oct_y;
  logic [mco_pkg::CENTER_W-1:0] center_col;
  logic [mco_pkg::CENTER_W-1:0] center_row;
  logic [mco_pkg::COLOR_W-1:0]  draw_color;

  assign cfg_ready = 1'b1;

  mco_octant_walk #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .in_color     (in_color),
    .can_load     (can_load),
    .launch       (launch),
    .oct_x        (oct_x),
    .oct_y        (oct_y),
    .center_col   (center_col),
    .center_row   (center_row),
    .draw_color   (draw_color)
  );

  mco_pixel_emit #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .launch           (launch),
    .oct_x            (oct_x),
    .oct_y            (oct_y),
    .center_col       (center_col),
    .center_row       (center_row),
    .draw_color       (draw_color),
    .cfg_valid        (cfg_valid),
    .cfg_row_pitch    (cfg_row_pitch),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_offset  (out_byte_offset),
    .out_pixel_value  (out_pixel_value),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

  `MCO_ASSERT_IMPL(a_done_on_last, clk, rst_n, out_valid && out_circle_done, out_last_of_step)
  `MCO_ASSERT_IMPL(a_load_from_step, clk, rst_n, launch.load, in_valid && in_ready && (in_operation == mco_pkg::OP_STEP))
  `MCO_ASSERT_IMPL(a_load_has_slot, clk, rst_n, launch.load, can_load)
  `MCO_ASSERT_NEXT(a_load_fills_output, clk, rst_n, launch.load, !can_load || out_valid)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
module tb_top;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASE_ITEMS     = 46;
  localparam int RADIUS_W        = 11;
  localparam int BYTES_PER_PIXEL = 4;

  typedef struct {
    logic signed [mco_pkg::COORD_W-1:0]  col;
    logic signed [mco_pkg::COORD_W-1:0]  row;
    logic signed [mco_pkg::OFFSET_W-1:0] offset;
    logic [mco_pkg::COLOR_W-1:0]         value;
    logic                                last_step;
    logic                                done;
  } pixel_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_operation;
  logic [mco_pkg::CENTER_W-1:0]        in_center_x;
  logic [mco_pkg::CENTER_W-1:0]        in_center_y;
  logic [RADIUS_W-1:0]                 in_radius;
  logic [mco_pkg::COLOR_W-1:0]         in_color;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [mco_pkg::COORD_W-1:0]  out_pixel_x;
  logic signed [mco_pkg::COORD_W-1:0]  out_pixel_y;
  logic signed [mco_pkg::OFFSET_W-1:0] out_byte_offset;
  logic [mco_pkg::COLOR_W-1:0]         out_pixel_value;
  logic                                out_last_of_step;
  logic                                out_circle_done;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [mco_pkg::PITCH_W-1:0]         cfg_row_pitch;

  // outline walker state
  int                          surf_pitch;
  bit                          circ_active;
  int                          oct_x;
  int                          oct_y;
  int                          dec_err;
  int                          ctr_col;
  int                          ctr_row;
  logic [mco_pkg::COLOR_W-1:0] draw_color;
  pixel_t                      pending_pixels[$];

  int err_count;
  int work_items;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  midpoint_circle_outline_unit #(
    .RADIUS_BITS(RADIUS_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_byte_offset (out_byte_offset),
    .out_pixel_value (out_pixel_value),
    .out_last_of_step(out_last_of_step),
    .out_circle_done (out_circle_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_row_pitch   (cfg_row_pitch)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic queue_pixel(input int px, input int py, input bit last, input bit done);
    longint ofs;
    pixel_t p;
    ofs = longint'(py) * longint'(surf_pitch) + longint'(BYTES_PER_PIXEL) * longint'(px);
    p.col       = px[mco_pkg::COORD_W-1:0];
    p.row       = py[mco_pkg::COORD_W-1:0];
    p.offset    = ofs[mco_pkg::OFFSET_W-1:0];
    p.value     = draw_color;
    p.last_step = last;
    p.done      = done;
    pending_pixels.push_back(p);
  endtask

  task automatic predict_request(input logic op, input logic [mco_pkg::CENTER_W-1:0] cx,
                                 input logic [mco_pkg::CENTER_W-1:0] cy,
                                 input logic [RADIUS_W-1:0] r,
                                 input logic [mco_pkg::COLOR_W-1:0] col);
    int nx;
    int ny;
    int ne;
    bit done;
    if (op == mco_pkg::OP_START) begin
      ctr_col     = int'(cx);
      ctr_row     = int'(cy);
      draw_color  = col;
      oct_x       = int'(r);
      oct_y       = 1;
      dec_err     = -oct_x;
      circ_active = 1'b1;
      work_items++;
    end else if (!circ_active || oct_x < oct_y) begin
      circ_active = 1'b0;
    end else begin
      ne = dec_err + 2 * oct_y;
      ny = oct_y + 1;
      nx = oct_x;
      if (ne >= 0) begin
        nx = nx - 1;
        ne = ne - (2 * nx - 1);
      end
      done = nx < ny;
      queue_pixel(ctr_col + oct_x - 1, ctr_row + oct_y - 1, 1'b0, 1'b0);
      queue_pixel(ctr_col + oct_y - 1, ctr_row + oct_x - 1, 1'b0, 1'b0);
      queue_pixel(ctr_col - oct_x,     ctr_row + oct_y - 1, 1'b0, 1'b0);
      queue_pixel(ctr_col + oct_y - 1, ctr_row - oct_x,     1'b0, 1'b0);
      queue_pixel(ctr_col + oct_x - 1, ctr_row - oct_y,     1'b0, 1'b0);
      queue_pixel(ctr_col - oct_y,     ctr_row + oct_x - 1, 1'b0, 1'b0);
      queue_pixel(ctr_col - oct_x,     ctr_row - oct_y,     1'b0, 1'b0);
      queue_pixel(ctr_col - oct_y,     ctr_row - oct_x,     1'b1, done);
      oct_x   = nx;
      oct_y   = ny;
      dec_err = ne;
      if (done) circ_active = 1'b0;
      work_items++;
    end
  endtask

  // check first, then take config and requests, all from pre-edge values
  always @(posedge clk) begin : pixel_monitor
    pixel_t exp_px;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel x %0d y %0d", $time, out_pixel_x, out_pixel_y);
          err_count++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_pixel_x !== exp_px.col) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, exp_px.col, out_pixel_x);
            err_count++;
          end
          if (out_pixel_y !== exp_px.row) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, exp_px.row, out_pixel_y);
            err_count++;
          end
          if (out_byte_offset !== exp_px.offset) begin
            $display("%0t: byte_offset expected %0d actual %0d", $time, exp_px.offset,
                     out_byte_offset);
            err_count++;
          end
          if (out_pixel_value !== exp_px.value) begin
            $display("%0t: pixel_value expected %h actual %h", $time, exp_px.value,
                     out_pixel_value);
            err_count++;
          end
          if (out_last_of_step !== exp_px.last_step) begin
            $display("%0t: last_of_step expected %b actual %b", $time, exp_px.last_step,
                     out_last_of_step);
            err_count++;
          end
          if (out_circle_done !== exp_px.done) begin
            $display("%0t: circle_done expected %b actual %b", $time, exp_px.done,
                     out_circle_done);
            err_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) surf_pitch = int'(cfg_row_pitch);
      if (in_valid && in_ready)
        predict_request(in_operation, in_center_x, in_center_y, in_radius, in_color);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called and returns at a falling edge; valid stays up for the next request
  task automatic send_request(input logic op, input logic [mco_pkg::CENTER_W-1:0] cx,
                              input logic [mco_pkg::CENTER_W-1:0] cy,
                              input logic [RADIUS_W-1:0] r,
                              input logic [mco_pkg::COLOR_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_center_x  <= cx;
    in_center_y  <= cy;
    in_radius    <= r;
    in_color     <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // unused fields of a step request carry noise
  task automatic send_step();
    send_request(mco_pkg::OP_STEP, mco_pkg::CENTER_W'($urandom),
                 mco_pkg::CENTER_W'($urandom), RADIUS_W'($urandom), $urandom);
  endtask

  task automatic walk_circle(input int max_steps);
    int k;
    k = 0;
    while (circ_active && k < max_steps) begin
      send_step();
      k++;
    end
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // a start or an empty step leaves nothing to wait on, so pad a little
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_pitch(input logic [mco_pkg::PITCH_W-1:0] pitch);
    cfg_valid     <= 1'b1;
    cfg_row_pitch <= pitch;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_step_without_circle();
    send_step();
  endtask

  // x starts below y, so the first step is empty and closes the circle
  task automatic test_zero_radius();
    send_request(mco_pkg::OP_START, '0, '0, '0, '0);
    send_step();
    send_step();
  endtask

  task automatic test_unit_radius();
    send_request(mco_pkg::OP_START, '1, '1, RADIUS_W'(1), '1);
    send_step();
    send_step();
  endtask

  // largest radius at opposite corners, second start abandons the first circle
  task automatic test_extreme_radius();
    send_request(mco_pkg::OP_START, '0, '1, '1, 32'hA5A5_5A5A);
    walk_circle(3);
    send_request(mco_pkg::OP_START, '1, '0, '1, $urandom);
    walk_circle(2);
  endtask

  task automatic test_full_circle();
    send_request(mco_pkg::OP_START, mco_pkg::CENTER_W'(2048), mco_pkg::CENTER_W'(1),
                 RADIUS_W'(6), $urandom);
    walk_circle(100);
    send_step();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [mco_pkg::PITCH_W-1:0] pitch);
    int target;
    int sel;
    int r;
    int cap;
    drain_pixels();
    write_pitch(pitch);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = work_items + PHASE_ITEMS;
    while (work_items < target) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        send_request(1'($urandom_range(1)), mco_pkg::CENTER_W'($urandom),
                     mco_pkg::CENTER_W'($urandom), RADIUS_W'($urandom), $urandom);
      end else if (sel < 13) begin
        drain_pixels();
      end else begin
        r = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(24);
        send_request(mco_pkg::OP_START, mco_pkg::CENTER_W'($urandom),
                     mco_pkg::CENTER_W'($urandom), RADIUS_W'(r), $urandom);
        // big circles are only walked a few steps
        cap = (r > 40) ? $urandom_range(1, 4) : 4096;
        if ($urandom_range(9) == 0) cap = $urandom_range(0, 3);
        walk_circle(cap);
        if ($urandom_range(3) == 0) send_step();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = mco_pkg::OP_START;
    in_center_x    = '0;
    in_center_y    = '0;
    in_radius      = '0;
    in_color       = '0;
    out_ready      = 1'b1;
    cfg_valid      = 1'b0;
    cfg_row_pitch  = mco_pkg::PITCH_RESET;
    surf_pitch     = int'(mco_pkg::PITCH_RESET);
    circ_active    = 1'b0;
    oct_x          = 0;
    oct_y          = 0;
    dec_err        = 0;
    ctr_col        = 0;
    ctr_row        = 0;
    draw_color     = '0;
    err_count      = 0;
    work_items     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_step_without_circle();
    test_zero_radius();
    test_unit_radius();
    test_extreme_radius();
    test_full_circle();

    test_random_phase(0, 0, mco_pkg::PITCH_W'(4));
    test_random_phase(59, 0, mco_pkg::PITCH_W'(16384));
    test_random_phase(0, 59, '1);
    test_random_phase(20, 20, '0);
    test_random_phase(20, 20, mco_pkg::PITCH_W'($urandom_range(4, 16384)));

    drain_pixels();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
